// ----- hw/rtl/modbus_rtu_reply_checker_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Modbus RTU reply checker
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_REPLY_CHECKER_CORE_DEFINES_SVH
`define MODBUS_RTU_REPLY_CHECKER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define MRRC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mrrc assertion failed");
// next-cycle implication
`define MRRC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mrrc assertion failed");
`else
`define MRRC_ASSERT_NOW(label, ante, cons)
`define MRRC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hw/rtl/mrrc_pkg.sv -----
// ----------------------------------------------------------------------------
// mrrc_pkg
// Shared types, constants and the CRC-16/Modbus byte update.
// ----------------------------------------------------------------------------
package mrrc_pkg;

	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [8:0]  CNT_MAX    = 9'd511;
	localparam logic [8:0]  LIMIT_RST  = 9'd255;
	localparam logic [7:0]  EXC_THRESH = 8'h80;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_CRC_BAD  = 3'd2,
		ST_LEN_OVER = 3'd3,
		ST_TRUNC    = 3'd4
	} status_t;

	typedef struct packed {
		logic        is_summary;
		logic [7:0]  data_byte;
		logic [7:0]  data_index;
		logic [7:0]  slave_addr;
		logic [7:0]  func_code;
		logic [7:0]  data_len;
		status_t     status;
		logic        exception;
		logic [15:0] rx_crc;
	} result_t;

	// Reflected CRC-16, one byte, eight unrolled shift steps
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/modbus_rtu_reply_checker_core.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_reply_checker_core
// Checks Modbus RTU reply frames: header parse, data emission, CRC-16 check.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid/in_stall, byte + eof    | to core
//  out     | out_valid/out_stall, result      | from core
//  cfg     | cfg_wr_en/cfg_wr_data (limit)    | to core
//
// One byte per cycle unless a stalled result holds it; results are registered.
// The CRC update is one unrolled byte step between input and result register.
// Reset clears frame state and sets the length limit to 255.
// While a result is stalled, one more byte is held in the input register.
// Bytes that give no result pass through even while the output is stalled.
// ----------------------------------------------------------------------------
`include "modbus_rtu_reply_checker_core_defines.svh"

module modbus_rtu_reply_checker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [8:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        end_of_frame,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_summary,
	output logic [7:0]  data_byte,
	output logic [7:0]  data_index,
	output logic [7:0]  slave_addr,
	output logic [7:0]  func_code,
	output logic [7:0]  data_len,
	output logic [2:0]  status,
	output logic        exception,
	output logic [15:0] rx_crc
);

	logic [8:0]        len_limit_q;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              eof_s1;
	logic              advance;
	logic              has_result;
	logic              out_ready;
	mrrc_pkg::result_t res;
	mrrc_pkg::result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_limit_q <= mrrc_pkg::LIMIT_RST;
		end else if (cfg_wr_en) begin
			len_limit_q <= cfg_wr_data;
		end
	end

	// advance a byte unless its result has nowhere to go
	assign advance = valid_s1 && (!has_result || out_ready);

	mrrc_in_reg u_in (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.end_of_frame (end_of_frame),
		.advance      (advance),
		.valid_s1     (valid_s1),
		.byte_s1      (byte_s1),
		.eof_s1       (eof_s1)
	);

	mrrc_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.byte_s1    (byte_s1),
		.eof_s1     (eof_s1),
		.limit      (len_limit_q),
		.has_result (has_result),
		.res        (res)
	);

	mrrc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && has_result),
		.res       (res),
		.out_stall (out_stall),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign is_summary = res_q.is_summary;
	assign data_byte  = res_q.data_byte;
	assign data_index = res_q.data_index;
	assign slave_addr = res_q.slave_addr;
	assign func_code  = res_q.func_code;
	assign data_len   = res_q.data_len;
	assign status     = res_q.status;
	assign exception  = res_q.exception;
	assign rx_crc     = res_q.rx_crc;

	`MRRC_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1 && $stable(byte_s1))
	`MRRC_ASSERT_NOW(a_no_overwrite, out_valid && out_stall, !(advance && has_result))
	`MRRC_ASSERT_NEXT(a_result_loaded, advance && has_result, out_valid)
	`MRRC_ASSERT_NOW(a_short_empty,
		out_valid && is_summary && status == mrrc_pkg::ST_SHORT,
		slave_addr == 8'd0 && rx_crc == 16'd0 && data_len == 8'd0)
	`MRRC_ASSERT_NEXT(a_limit_hold, !cfg_wr_en, $stable(len_limit_q))

endmodule

// ----- hw/rtl/mrrc_in_reg.sv -----
// ----------------------------------------------------------------------------
// mrrc_in_reg
// Input register: holds one received byte until the frame logic takes it.
// ----------------------------------------------------------------------------
module mrrc_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       end_of_frame,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       eof_s1
);

	logic take;

	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= rx_byte;
			eof_s1  <= end_of_frame;
		end
	end

endmodule

// ----- hw/rtl/mrrc_frame.sv -----
// ----------------------------------------------------------------------------
// mrrc_frame
// Frame parser: header fields, delay line, CRC and data/summary results.
// ----------------------------------------------------------------------------
module mrrc_frame (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [7:0]        byte_s1,
	input  logic              eof_s1,
	input  logic [8:0]        limit,
	output logic              has_result,
	output mrrc_pkg::result_t res
);

	logic [15:0] crc_q;
	logic [7:0]  dly0_q;
	logic [7:0]  dly1_q;
	logic [8:0]  cnt_q;
	logic [7:0]  addr_q;
	logic [7:0]  fcode_q;
	logic [7:0]  len_q;
	logic        wide_q;
	logic [7:0]  dcnt_q;

	logic [15:0] crc_d;
	logic [8:0]  cnt_d;
	logic [7:0]  addr_d;
	logic [7:0]  fcode_d;
	logic [7:0]  len_d;
	logic        wide_d;
	logic        emit;
	logic [8:0]  p;
	logic [8:0]  hdr;
	logic        hdr_ok;
	logic        lim_ok;
	logic [15:0] rx;
	logic [7:0]  fc;

	always_comb begin
		crc_d   = (cnt_q >= 9'd2) ? mrrc_pkg::crc16_byte(crc_q, dly0_q) : crc_q;
		cnt_d   = (cnt_q == mrrc_pkg::CNT_MAX) ? mrrc_pkg::CNT_MAX : cnt_q + 9'd1;
		addr_d  = addr_q;
		fcode_d = fcode_q;
		len_d   = len_q;
		wide_d  = wide_q;
		emit    = 1'b0;
		if (cnt_q == 9'd0) begin
			addr_d = byte_s1;
		end else if (cnt_q == 9'd1) begin
			fcode_d = byte_s1;
		end else if (cnt_q == 9'd2) begin
			if (byte_s1 == 8'd0) begin
				wide_d = 1'b1;
			end else begin
				len_d = byte_s1;
			end
		end else if (cnt_q == 9'd3 && wide_q) begin
			len_d = byte_s1;
		end else if (cnt_q != mrrc_pkg::CNT_MAX) begin
			emit = ({1'b0, len_q} < limit) && (dcnt_q < len_q) && !eof_s1;
		end

		// summary view uses the state as updated by this byte
		p      = cnt_d - 9'd2;
		hdr    = 9'd3 + {8'd0, wide_d};
		hdr_ok = p >= hdr;
		lim_ok = {1'b0, len_d} < limit;
		rx     = {byte_s1, dly1_q};
		fc     = (p >= 9'd2) ? fcode_d : 8'd0;

		res = '0;
		has_result = eof_s1 || emit;
		if (eof_s1) begin
			res.is_summary = 1'b1;
			if (cnt_q == 9'd0) begin
				res.status = mrrc_pkg::ST_SHORT;
			end else begin
				res.slave_addr = (p >= 9'd1) ? addr_d : 8'd0;
				res.func_code  = fc;
				res.data_len   = (hdr_ok && lim_ok) ? len_d : 8'd0;
				res.exception  = fc >= mrrc_pkg::EXC_THRESH;
				res.rx_crc     = rx;
				if (rx != crc_d) begin
					res.status = mrrc_pkg::ST_CRC_BAD;
				end else if (!hdr_ok) begin
					res.status = mrrc_pkg::ST_TRUNC;
				end else if (!lim_ok) begin
					res.status = mrrc_pkg::ST_LEN_OVER;
				end else if ((p - hdr) < {1'b0, len_d}) begin
					res.status = mrrc_pkg::ST_TRUNC;
				end else begin
					res.status = mrrc_pkg::ST_OK;
				end
			end
		end else if (emit) begin
			res.data_byte  = byte_s1;
			res.data_index = dcnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= mrrc_pkg::CRC_INIT;
			dly0_q  <= '0;
			dly1_q  <= '0;
			cnt_q   <= '0;
			addr_q  <= '0;
			fcode_q <= '0;
			len_q   <= '0;
			wide_q  <= 1'b0;
			dcnt_q  <= '0;
		end else if (advance) begin
			if (eof_s1) begin
				// drop all frame state after the summary
				crc_q   <= mrrc_pkg::CRC_INIT;
				dly0_q  <= '0;
				dly1_q  <= '0;
				cnt_q   <= '0;
				addr_q  <= '0;
				fcode_q <= '0;
				len_q   <= '0;
				wide_q  <= 1'b0;
				dcnt_q  <= '0;
			end else begin
				crc_q   <= crc_d;
				dly0_q  <= dly1_q;
				dly1_q  <= byte_s1;
				cnt_q   <= cnt_d;
				addr_q  <= addr_d;
				fcode_q <= fcode_d;
				len_q   <= len_d;
				wide_q  <= wide_d;
				if (emit) begin
					dcnt_q <= dcnt_q + 8'd1;
				end
			end
		end
	end

endmodule

// ----- hw/rtl/mrrc_out_reg.sv -----
// ----------------------------------------------------------------------------
// mrrc_out_reg
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module mrrc_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  mrrc_pkg::result_t res,
	input  logic              out_stall,
	output logic              out_ready,
	output logic              out_valid,
	output mrrc_pkg::result_t res_q
);

	assign out_ready = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// ----- sim/tb_modbus_rtu_reply_checker_core.sv -----
// ----------------------------------------------------------------------------
// tb_modbus_rtu_reply_checker_core
// Feeds Modbus RTU reply frames byte by byte with random gaps and output
// stalls. An in-bench predictor tracks header parse, data emission and the
// CRC-16 check, and every result is compared with the oldest prediction.
// The length limit is changed between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_reply_checker_core;
	import mrrc_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PIPE_SETTLE  = 8;
	localparam int PHASE_BYTES  = 6;

	typedef logic [7:0] frame_t[$];

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [8:0]  cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = '0;
	logic        end_of_frame = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        is_summary;
	logic [7:0]  data_byte;
	logic [7:0]  data_index;
	logic [7:0]  slave_addr;
	logic [7:0]  func_code;
	logic [7:0]  data_len;
	logic [2:0]  status;
	logic        exception;
	logic [15:0] rx_crc;

	int          cycles = 0;
	int          limit_now = LIMIT_RST;
	bit          no_idle = 1'b0;
	int          rx_hold = 0;

	// Bitwise reflected CRC-16/Modbus, one byte
	function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb)
				c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	class reply_tracker;
		logic [8:0]  len_limit;
		logic [15:0] crc_run;
		logic [7:0]  tail [2];
		logic [8:0]  byte_pos;
		logic [7:0]  addr_q;
		logic [7:0]  fcode_q;
		logic [7:0]  len_q;
		logic        wide_len;
		logic [8:0]  payload_cnt;
		result_t     pending_results[$];
		int          mismatches;

		function new();
			len_limit = LIMIT_RST;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			crc_run = CRC_INIT;
			tail[0] = '0;
			tail[1] = '0;
			byte_pos = '0;
			addr_q = '0;
			fcode_q = '0;
			len_q = '0;
			wide_len = 1'b0;
			payload_cnt = '0;
		endfunction

		function void take_byte(logic [7:0] b, logic eof);
			int unsigned pos;
			int unsigned p;
			int unsigned hdr;
			logic        emit;
			logic        hdr_ok;
			logic        lim_ok;
			logic [7:0]  fc;
			result_t     r;
			pos = byte_pos;
			emit = 1'b0;
			r = '0;
			// the newest two bytes stay out of the CRC until pushed further
			if (pos >= 2)
				crc_run = crc16_step(crc_run, tail[0]);
			tail[0] = tail[1];
			tail[1] = b;
			if (pos == 0) begin
				addr_q = b;
			end else if (pos == 1) begin
				fcode_q = b;
			end else if (pos == 2) begin
				if (b == 8'h00)
					wide_len = 1'b1;
				else
					len_q = b;
			end else if (pos == 3 && wide_len) begin
				len_q = b;
			end else if (pos < CNT_MAX) begin
				emit = ({1'b0, len_q} < len_limit) && (payload_cnt < {1'b0, len_q}) && !eof;
			end
			byte_pos = (pos >= CNT_MAX) ? CNT_MAX : 9'(pos + 1);

			if (eof) begin
				r.is_summary = 1'b1;
				if (byte_pos < 2) begin
					r.status = ST_SHORT;
				end else begin
					p = byte_pos - 2;
					hdr = 3 + wide_len;
					fc = (p >= 2) ? fcode_q : 8'h00;
					hdr_ok = (p >= hdr);
					lim_ok = ({1'b0, len_q} < len_limit);
					r.rx_crc = {tail[1], tail[0]};
					if (r.rx_crc != crc_run)
						r.status = ST_CRC_BAD;
					else if (!hdr_ok)
						r.status = ST_TRUNC;
					else if (!lim_ok)
						r.status = ST_LEN_OVER;
					else if (p - hdr < len_q)
						r.status = ST_TRUNC;
					else
						r.status = ST_OK;
					r.slave_addr = (p >= 1) ? addr_q : 8'h00;
					r.func_code = fc;
					r.data_len = (hdr_ok && lim_ok) ? len_q : 8'h00;
					r.exception = (fc >= EXC_THRESH);
				end
				pending_results.push_back(r);
				restart();
			end else if (emit) begin
				r.data_byte = b;
				r.data_index = payload_cnt[7:0];
				payload_cnt = payload_cnt + 9'd1;
				pending_results.push_back(r);
			end
		endfunction

		function void compare(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void match_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				$error("result with nothing awaited: is_summary %0d", got.is_summary);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			compare("is_summary", want.is_summary, got.is_summary);
			compare("data_byte", want.data_byte, got.data_byte);
			compare("data_index", want.data_index, got.data_index);
			compare("slave_addr", want.slave_addr, got.slave_addr);
			compare("func_code", want.func_code, got.func_code);
			compare("data_len", want.data_len, got.data_len);
			compare("status", want.status, got.status);
			compare("exception", want.exception, got.exception);
			compare("rx_crc", want.rx_crc, got.rx_crc);
		endfunction
	endclass

	reply_tracker tracker = new();

	modbus_rtu_reply_checker_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.end_of_frame (end_of_frame),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.is_summary   (is_summary),
		.data_byte    (data_byte),
		.data_index   (data_index),
		.slave_addr   (slave_addr),
		.func_code    (func_code),
		.data_len     (data_len),
		.status       (status),
		.exception    (exception),
		.rx_crc       (rx_crc)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_modbus_rtu_reply_checker_core failed");
			$finish;
		end
	end

	function automatic int pick_wait();
		if (no_idle || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 14);
	endfunction

	// Result side: check each transfer, then stall for a random count
	always @(posedge clk) begin
		result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.is_summary = is_summary;
			got.data_byte = data_byte;
			got.data_index = data_index;
			got.slave_addr = slave_addr;
			got.func_code = func_code;
			got.data_len = data_len;
			got.status = status_t'(status);
			got.exception = exception;
			got.rx_crc = rx_crc;
			tracker.match_result(got);
			rx_hold = pick_wait();
		end else if (rx_hold > 0) begin
			rx_hold--;
		end
		out_stall <= (rx_hold > 0);
	end

	task automatic send_byte(logic [7:0] b, logic eof);
		int gap;
		gap = pick_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		end_of_frame <= eof;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.take_byte(b, eof);
	endtask

	task automatic send_frame(frame_t f);
		for (int i = 0; i < f.size(); i++)
			send_byte(f[i], i == f.size() - 1);
	endtask

	// Drop valid, wait for every awaited result, then let the pipe empty
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	task automatic program_limit(int v);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v[8:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.len_limit = v[8:0];
		limit_now = v;
	endtask

	function automatic frame_t seal(frame_t f);
		logic [15:0] c;
		c = CRC_INIT;
		foreach (f[i])
			c = crc16_step(c, f[i]);
		f.push_back(c[7:0]);
		f.push_back(c[15:8]);
		return f;
	endfunction

	task automatic make_frame(output frame_t f);
		int   kind;
		int   r;
		int   len;
		int   nd;
		int   lo;
		int   hi;
		int   cut;
		logic wide;
		f = {};
		kind = $urandom_range(0, 99);
		if (kind >= 88) begin
			// noise: random bytes, no CRC
			repeat ($urandom_range(1, 10)) f.push_back(8'($urandom));
			return;
		end
		r = $urandom_range(0, 99);
		if (r < 80) begin
			len = $urandom_range(1, 12);
		end else if (r < 92) begin
			lo = (limit_now > 1) ? limit_now - 1 : 1;
			hi = limit_now + 1;
			if (lo > 255) lo = 255;
			if (hi > 255) hi = 255;
			len = $urandom_range(lo, hi);
		end else if (r < 96) begin
			len = $urandom_range(13, 60);
		end else begin
			len = $urandom_range(61, 255);
		end
		wide = ($urandom_range(0, 3) == 0);
		if (wide && $urandom_range(0, 7) == 0)
			len = 0;
		f.push_back(8'($urandom));
		f.push_back(8'($urandom));
		if (wide)
			f.push_back(8'h00);
		f.push_back(len[7:0]);
		nd = len;
		if (len >= limit_now)
			nd = $urandom_range(0, 6);
		else if (len > 40 && $urandom_range(0, 2) != 0)
			nd = $urandom_range(0, 8);
		if (kind >= 70 && kind < 80) begin
			// short of the declared data, sometimes short of the header
			if ($urandom_range(0, 3) == 0) begin
				cut = $urandom_range(0, f.size() - 1);
				while (f.size() > cut)
					void'(f.pop_back());
				nd = 0;
			end else begin
				nd = $urandom_range(0, nd);
			end
		end else if (kind >= 80) begin
			nd += $urandom_range(1, 4);
		end
		repeat (nd) f.push_back(8'($urandom));
		f = seal(f);
		if ($urandom_range(0, 99) < 15)
			f[f.size() - 1 - $urandom_range(0, 1)] ^= 8'h01 << $urandom_range(0, 7);
	endtask

	initial begin
		frame_t f;
		int     sent;
		int     phase_limit [7];
		phase_limit = '{LIMIT_RST, 0, 1, 256, 511, 0, 255};
		phase_limit[5] = $urandom_range(2, 254);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single byte, two bytes, minimal frame, exception reply, wide length
		send_frame({8'h00});
		send_frame({8'hFF, 8'hFF});
		send_frame(seal({8'h01, 8'h03, 8'h01, 8'h00}));
		send_frame(seal({8'hFF, 8'h83, 8'h02, 8'hFF, 8'h80}));
		send_frame(seal({8'h11, 8'h7F, 8'h00, 8'h02, 8'h55, 8'hAA}));

		for (int ph = 0; ph < 7; ph++) begin
			if (ph > 0)
				program_limit(phase_limit[ph]);
			no_idle = (ph % 3 == 2);
			sent = 0;
			while (sent < PHASE_BYTES) begin
				make_frame(f);
				send_frame(f);
				sent += f.size();
				if ($urandom_range(0, 9) == 0)
					settle();
			end
			if (ph == 4) begin
				// run the byte counter into saturation
				f = {8'h42, 8'h04, 8'h0A};
				repeat (509) f.push_back(8'($urandom));
				send_frame(seal(f));
			end
		end

		settle();
		if (tracker.mismatches == 0)
			$display("tb_modbus_rtu_reply_checker_core passed");
		else
			$display("tb_modbus_rtu_reply_checker_core failed");
		$finish;
	end

endmodule
